[rtl/rws_pkg.sv]
// shared constants and types for the roulette wheel selector
package rws_pkg;

   localparam int MAX_ENTRIES    = 64;
   localparam int FITNESS_BITS   = 24;
   localparam int PIN_BITS       = 16;
   localparam int CSR_COUNT_BITS = 7;

   localparam int IDX_BITS   = $clog2(MAX_ENTRIES);
   localparam int COUNT_BITS = IDX_BITS + 1;
   localparam int TOTAL_BITS = FITNESS_BITS + IDX_BITS;
   localparam int PROD_BITS  = TOTAL_BITS + PIN_BITS;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_DRAW = 1'b1;

   typedef struct packed {
      logic                    en;
      logic [IDX_BITS-1:0]     addr;
      logic [FITNESS_BITS-1:0] data;
   } tbl_wr_type;

endpackage

[rtl/rws_table.sv]
// fitness table: synchronous memory with per-entry valid bits
module rws_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [rws_pkg::IDX_BITS-1:0]     rd_addr,
   input  rws_pkg::tbl_wr_type              wr,
   output logic [rws_pkg::FITNESS_BITS-1:0] rd_data
);

   logic [rws_pkg::FITNESS_BITS-1:0] table_mem [rws_pkg::MAX_ENTRIES];
   logic [rws_pkg::MAX_ENTRIES-1:0]  valid_ff;
   logic [rws_pkg::FITNESS_BITS-1:0] rd_data_ff;
   logic                             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         table_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
      end
   end

   // entries never written read as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

[rtl/roulette_wheel_selector_unit.sv]
// top level of the roulette wheel selector
//
// fitness-proportionate selection over a table of unsigned fitness values
// input transaction: taken on a clock edge with start high and busy low
//   action load: writes fitness_value into slot entry_index and updates the
//                running total; gives no result
//   action draw: walks cumulative sums from entry 0 while
//                pin * total > partial << PIN_BITS and index < count-1
// result: rsp_valid strobes for one cycle with rsp_selected_index
//   the walk reads one table entry per cycle from the single read port;
//   busy drops as the result shows, so the next transaction can be taken
//   on the edge that takes the result
// csr port: csr_write_enable writes population_count (clamped to 1..64);
//   the user must write it only while idle; the block does not enforce this
// reset: synchronous, clears the total, marks every table entry as zero
//   through valid bits and sets population_count to 64; no clearing pass
// the receiver cannot stall: each result is shown once and is gone after
module roulette_wheel_selector_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_action,
   input  logic [rws_pkg::IDX_BITS-1:0]          req_entry_index,
   input  logic [rws_pkg::FITNESS_BITS-1:0]      req_fitness_value,
   input  logic [rws_pkg::PIN_BITS-1:0]          req_random_pin,
   output logic                                  rsp_valid,
   output logic [rws_pkg::IDX_BITS-1:0]          rsp_selected_index,
   input  logic                                  csr_write_enable,
   input  logic [rws_pkg::CSR_COUNT_BITS-1:0]    csr_population_count
);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOAD  = 2'd1;
   localparam logic [1:0] ST_FIRST = 2'd2;
   localparam logic [1:0] ST_WALK  = 2'd3;

   logic [1:0]                         state_ff, state_in;
   logic [rws_pkg::COUNT_BITS-1:0]     count_lim_ff, count_lim_in;
   logic [rws_pkg::TOTAL_BITS-1:0]     total_ff, total_in;
   logic [rws_pkg::TOTAL_BITS-1:0]     partial_ff, partial_in;
   logic [rws_pkg::PROD_BITS-1:0]      lhs_ff;
   logic [rws_pkg::IDX_BITS-1:0]       k_ff, k_in;
   logic [rws_pkg::IDX_BITS-1:0]       idx_ff;
   logic [rws_pkg::FITNESS_BITS-1:0]   fit_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rws_pkg::IDX_BITS-1:0]       rsp_index_ff, rsp_index_in;

   logic                               accept;
   logic [rws_pkg::IDX_BITS-1:0]       rd_addr;
   logic [rws_pkg::FITNESS_BITS-1:0]   rd_data;
   rws_pkg::tbl_wr_type                wr;
   logic [rws_pkg::COUNT_BITS-1:0]     k_inc;
   logic                               beyond;
   logic                               step;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // clamp the count to 1..MAX_ENTRIES when it is written
   always_comb begin
      count_lim_in = count_lim_ff;
      if (csr_write_enable) begin
         if (csr_population_count == '0) begin
            count_lim_in = rws_pkg::COUNT_BITS'(1);
         end else if (32'(csr_population_count) > 32'(rws_pkg::MAX_ENTRIES)) begin
            count_lim_in = rws_pkg::COUNT_BITS'(rws_pkg::MAX_ENTRIES);
         end else begin
            count_lim_in = rws_pkg::COUNT_BITS'(csr_population_count);
         end
      end
   end

   // table read address: the walk prefetches one entry ahead
   always_comb begin
      case (state_ff)
         ST_IDLE:  rd_addr = (req_action == rws_pkg::ACTION_DRAW) ? '0 : req_entry_index;
         ST_FIRST: rd_addr = rws_pkg::IDX_BITS'(1);
         ST_WALK:  rd_addr = k_ff + rws_pkg::IDX_BITS'(2);
         default:  rd_addr = idx_ff;
      endcase
   end

   // load writes back in the cycle after the old value is read
   assign wr.en   = (state_ff == ST_LOAD);
   assign wr.addr = idx_ff;
   assign wr.data = fit_ff;

   rws_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd_data (rd_data)
   );

   // exact compare of pin * total against partial scaled by the pin width
   assign beyond = lhs_ff > {partial_ff, {rws_pkg::PIN_BITS{1'b0}}};
   assign k_inc  = {1'b0, k_ff} + rws_pkg::COUNT_BITS'(1);
   assign step   = (k_inc < count_lim_ff) && beyond;

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      partial_in   = partial_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               k_in     = '0;
               state_in = (req_action == rws_pkg::ACTION_DRAW) ? ST_FIRST : ST_LOAD;
            end
         end
         ST_LOAD: begin
            // subtract the old entry, add the new one
            total_in = total_ff - rws_pkg::TOTAL_BITS'(rd_data)
                       + rws_pkg::TOTAL_BITS'(fit_ff);
            state_in = ST_IDLE;
         end
         ST_FIRST: begin
            partial_in = rws_pkg::TOTAL_BITS'(rd_data);
            state_in   = ST_WALK;
         end
         ST_WALK: begin
            if (step) begin
               // rd_data already holds entry k+1
               k_in       = k_inc[rws_pkg::IDX_BITS-1:0];
               partial_in = partial_ff + rws_pkg::TOTAL_BITS'(rd_data);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_index_in = k_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_lim_ff <= rws_pkg::COUNT_BITS'(rws_pkg::MAX_ENTRIES);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_lim_ff <= count_lim_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // transaction payload and walk datapath
   always_ff @(posedge clock) begin
      partial_ff   <= partial_in;
      k_ff         <= k_in;
      rsp_index_ff <= rsp_index_in;
      if (accept) begin
         idx_ff <= req_entry_index;
         fit_ff <= req_fitness_value;
         lhs_ff <= rws_pkg::PROD_BITS'(req_random_pin) * rws_pkg::PROD_BITS'(total_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_selected_index = rsp_index_ff;

`ifndef SYNTHESIS
   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_WALK)
      else $error("result without a finished walk");

   a_rsp_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_selected_index} < count_lim_ff)
      else $error("selected index beyond population count");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> k_inc <= count_lim_ff)
      else $error("walk ran past population count");

   a_write_only_load: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> $past(accept) && $past(req_action) == rws_pkg::ACTION_LOAD)
      else $error("table write outside a load");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");
`endif

endmodule

[sim/roulette_wheel_selector_checker.sv]
// checker for the roulette wheel selector: tracks the table, predicts each draw, compares results
`timescale 1ns / 1ps

module roulette_wheel_selector_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic                                  req_action,
   input  logic [rws_pkg::IDX_BITS-1:0]          req_entry_index,
   input  logic [rws_pkg::FITNESS_BITS-1:0]      req_fitness_value,
   input  logic [rws_pkg::PIN_BITS-1:0]          req_random_pin,
   input  logic                                  rsp_valid,
   input  logic [rws_pkg::IDX_BITS-1:0]          rsp_selected_index,
   input  logic                                  csr_write_enable,
   input  logic [rws_pkg::CSR_COUNT_BITS-1:0]    csr_population_count,
   output int                                    fault_count,
   output int                                    pending_draws
);
   import rws_pkg::*;

   logic [FITNESS_BITS-1:0]   wheel_table [MAX_ENTRIES];
   logic [TOTAL_BITS-1:0]     wheel_total;
   logic [CSR_COUNT_BITS-1:0] count_csr;
   logic [IDX_BITS-1:0]       expected_picks [$];
   logic [IDX_BITS-1:0]       want_pick;

   initial begin
      fault_count   = 0;
      pending_draws = 0;
   end

   // walk the cumulative sums exactly as the block should
   function automatic logic [IDX_BITS-1:0] predict_pick(input logic [PIN_BITS-1:0] pin);
      int          span;
      int          k;
      logic [63:0] partial;
      logic [63:0] weighted;
      if (count_csr == 0)
         span = 1;
      else if (count_csr > MAX_ENTRIES)
         span = MAX_ENTRIES;
      else
         span = int'(count_csr);
      k = 0;
      if (wheel_total != 0) begin
         partial  = 64'(wheel_table[0]);
         weighted = 64'(pin) * 64'(wheel_total);
         while (k + 1 < span && weighted > (partial << PIN_BITS)) begin
            k++;
            partial += 64'(wheel_table[k]);
         end
      end
      return IDX_BITS'(k);
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch at %0t ns: %s, expected %0d, got %0d", $time, what, want, got);
      fault_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++)
            wheel_table[i] = '0;
         wheel_total = '0;
         count_csr   = CSR_COUNT_BITS'(MAX_ENTRIES);
         expected_picks.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_picks.size() == 0) begin
               report_mismatch("result with no draw pending", -1, int'(rsp_selected_index));
            end else begin
               want_pick = expected_picks.pop_front();
               if (rsp_selected_index !== want_pick)
                  report_mismatch("selected_index", int'(want_pick), int'(rsp_selected_index));
            end
         end
         if (csr_write_enable === 1'b1)
            count_csr = csr_population_count;
         if (start === 1'b1 && busy === 1'b0) begin
            if (req_action == ACTION_DRAW) begin
               expected_picks.push_back(predict_pick(req_random_pin));
            end else begin
               wheel_total = wheel_total - TOTAL_BITS'(wheel_table[req_entry_index])
                           + TOTAL_BITS'(req_fitness_value);
               wheel_table[req_entry_index] = req_fitness_value;
            end
         end
      end
      pending_draws = expected_picks.size();
   end

endmodule

[sim/roulette_wheel_selector_unit_tb.sv]
// testbench top for the roulette wheel selector: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module roulette_wheel_selector_unit_tb;
   import rws_pkg::*;

   // watchdog limit, with a wide margin over the slowest correct run
   localparam int CYCLE_LIMIT  = 800000;
   localparam int PHASE_COUNT  = 10;
   localparam int PHASE_ITEMS  = 115;

   typedef struct packed {
      logic                    action;
      logic [IDX_BITS-1:0]     slot;
      logic [FITNESS_BITS-1:0] fitness;
      logic [PIN_BITS-1:0]     pin;
   } wheel_req_t;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_action;
   logic [IDX_BITS-1:0]       req_entry_index;
   logic [FITNESS_BITS-1:0]   req_fitness_value;
   logic [PIN_BITS-1:0]       req_random_pin;
   logic                      rsp_valid;
   logic [IDX_BITS-1:0]       rsp_selected_index;
   logic                      csr_write_enable;
   logic [CSR_COUNT_BITS-1:0] csr_population_count;

   int fault_count;
   int pending_draws;
   int cycle_count = 0;
   bit burst = 1'b0;   // when set, transactions go back to back

   roulette_wheel_selector_unit dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_action           (req_action),
      .req_entry_index      (req_entry_index),
      .req_fitness_value    (req_fitness_value),
      .req_random_pin       (req_random_pin),
      .rsp_valid            (rsp_valid),
      .rsp_selected_index   (rsp_selected_index),
      .csr_write_enable     (csr_write_enable),
      .csr_population_count (csr_population_count)
   );

   roulette_wheel_selector_checker checker_inst (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_action           (req_action),
      .req_entry_index      (req_entry_index),
      .req_fitness_value    (req_fitness_value),
      .req_random_pin       (req_random_pin),
      .rsp_valid            (rsp_valid),
      .rsp_selected_index   (rsp_selected_index),
      .csr_write_enable     (csr_write_enable),
      .csr_population_count (csr_population_count),
      .fault_count          (fault_count),
      .pending_draws        (pending_draws)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog: a hung handshake or a lost result ends the run here
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // present one transaction and hold it until the block takes it;
   // called and returns at a falling edge, so start never gets two updates in one step
   task automatic issue(input wheel_req_t r);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start             <= 1'b1;
      req_action        <= r.action;
      req_entry_index   <= r.slot;
      req_fitness_value <= r.fitness;
      req_random_pin    <= r.pin;
      // accepted at the rising edge where busy is low
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   task automatic load(input int slot, input logic [FITNESS_BITS-1:0] fitness);
      wheel_req_t r;
      r         = '0;
      r.action  = ACTION_LOAD;
      r.slot    = IDX_BITS'(slot);
      r.fitness = fitness;
      r.pin     = PIN_BITS'($urandom());
      issue(r);
   endtask

   task automatic draw(input logic [PIN_BITS-1:0] pin);
      wheel_req_t r;
      r         = '0;
      r.action  = ACTION_DRAW;
      r.slot    = IDX_BITS'($urandom());
      r.fitness = FITNESS_BITS'($urandom());
      r.pin     = pin;
      issue(r);
   endtask

   // wait until every draw has come back and the block is idle, then wait out
   // a trailing load before touching the count register
   task automatic drain();
      start <= 1'b0;
      while (pending_draws != 0) @(negedge clock);
      while (busy !== 1'b0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_count(input logic [CSR_COUNT_BITS-1:0] value);
      drain();
      csr_write_enable     <= 1'b1;
      csr_population_count <= value;
      @(negedge clock);
      csr_write_enable     <= 1'b0;
   endtask

   // random transaction; loads mostly land in the slots a draw can reach
   function automatic wheel_req_t random_req(input int profile, input int span);
      wheel_req_t r;
      r.action = ($urandom_range(0, 1) == 1) ? ACTION_DRAW : ACTION_LOAD;
      if ($urandom_range(0, 3) != 0)
         r.slot = IDX_BITS'($urandom_range(0, span - 1));
      else
         r.slot = IDX_BITS'($urandom_range(0, MAX_ENTRIES - 1));
      case (profile)
         0: begin
            r.fitness = FITNESS_BITS'($urandom());
         end
         1: begin
            r.fitness = FITNESS_BITS'($urandom_range(0, 255));
         end
         2: begin
            // mostly empty slots, so the walk crosses runs of zero weight
            r.fitness = ($urandom_range(0, 9) < 6) ? '0 : FITNESS_BITS'($urandom());
         end
         default: begin
            case ($urandom_range(0, 2))
               0: r.fitness = '0;
               1: r.fitness = '1;
               default: r.fitness = FITNESS_BITS'(1);
            endcase
         end
      endcase
      if ($urandom_range(0, 7) == 0)
         r.pin = ($urandom_range(0, 1) == 1) ? '1 : '0;
      else
         r.pin = PIN_BITS'($urandom_range(0, 65535));
      return r;
   endfunction

   initial begin
      logic [CSR_COUNT_BITS-1:0] phase_counts [PHASE_COUNT];
      int span;

      phase_counts = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd40, 7'd63, 7'd64, 7'd100, 7'd0};
      phase_counts[7] = CSR_COUNT_BITS'($urandom_range(0, 127));

      // every input known from time zero
      reset                = 1'b1;
      start                = 1'b0;
      req_action           = ACTION_LOAD;
      req_entry_index      = '0;
      req_fitness_value    = '0;
      req_random_pin       = '0;
      csr_write_enable     = 1'b0;
      csr_population_count = '0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      // empty table: total is zero, every draw must pick slot 0
      draw('0);
      draw('1);
      // heaviest weights at both ends of the table
      load(0, '1);
      load(MAX_ENTRIES - 1, '1);
      draw('0);
      draw('1);           // walks through the empty middle to the last slot
      draw(16'h8000);     // lands exactly on the boundary: not beyond, stays at 0
      draw(16'h8001);
      load(0, '0);        // old value is taken out of the total
      draw('0);
      draw(16'h0001);
      load(MAX_ENTRIES - 1, '0);
      draw('1);           // total back to zero

      // count of one: only slot 0 can come out
      set_count(7'd1);
      load(5, 24'h123456);
      draw('1);
      // count of zero behaves as one
      set_count(7'd0);
      draw('1);
      // count above the table size saturates to the full table
      set_count(7'd127);
      load(MAX_ENTRIES - 1, '1);
      draw('1);
      load(5, '0);
      // slots beyond the count still weigh in; the last live slot takes their share
      set_count(7'd2);
      load(0, 24'd1);
      load(1, 24'd1);
      draw('1);
      draw('0);

      // ---- random part: several count settings, each with its own weight profile ----
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_count(phase_counts[p]);
         if (phase_counts[p] == 0)
            span = 1;
         else if (phase_counts[p] > MAX_ENTRIES)
            span = MAX_ENTRIES;
         else
            span = int'(phase_counts[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // switch between idle gaps and back-to-back stretches now and then
            if ($urandom_range(0, 19) == 0)
               burst = ~burst;
            issue(random_req(p % 4, span));
         end
      end

      // all results in, then watch for any stray strobe over a full draw latency
      drain();
      repeat (70) @(negedge clock);

      if (fault_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
